### rtl/bmhq_pkg.sv
`default_nettype none
package bmhq_pkg;

  // Request codes.
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_EXT_MAX = 2'd1;
  localparam logic [1:0] REQ_EXT_MIN = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned CAP_BITS = 7;

  // Entry field widths; the stream ports are laid out for these.
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned PAYLOAD_BITS = 16;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ROOT,
    S_SCAN,
    S_SCAN_END,
    S_RD_LAST,
    S_PLACE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  // Memory port request from the sequencer to the store.
  typedef struct packed {
    logic wr_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

### rtl/bmhq_store.sv
`default_nettype none
// Heap storage: one write port and two synchronous read ports.
module bmhq_store #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 48
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] wa_i,
  input  wire logic [DW-1:0] wd_i,
  input  wire logic [AW-1:0] ra_i,
  input  wire logic [AW-1:0] rb_i,
  output logic      [DW-1:0] qa_o,
  output logic      [DW-1:0] qb_o
);
  logic [DW-1:0] mem_q [2**AW];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    qa_o <= mem_q[ra_i];
    qb_o <= mem_q[rb_i];
  end
endmodule
`default_nettype wire

### rtl/binary_max_heap_queue.sv
`default_nettype none
// Channel   Dir  Payload
// s_axis    in   tdata: in_key, in_payload; tuser: req_type
// m_axis    out  tdata: out_key, out_payload, status, entry_count
// cfg       in   capacity
// An insert climbs one level per parent compare; extract max descends one
// level per child compare; extract min first scans every held entry for the
// smallest key. Each step waits on a registered store read.
// One request is handled at a time.
// Reset empties the heap and sets capacity to 64; the store is not cleared.
// A stalled result holds in the output register, and no new request is taken
// until that result transfers.
module binary_max_heap_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] in_key, [47:32] in_payload
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] out_key, [47:32] out_payload, [49:48] status, [56:50] entry_count
  output logic [63:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);
  import bmhq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = KEY_BITS + PAYLOAD_BITS;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CAP_BITS-1:0] cap_q;
  logic [1:0] req_q, req_d;
  logic [DW-1:0] ent_q, ent_d;       // entry being placed or sifted
  logic [DW-1:0] res_q, res_d;       // extracted entry
  logic [AW-1:0] pos_q, pos_d;       // slot of ent_q
  logic [CW-1:0] scan_q, scan_d;     // next slot to scan
  logic [DW-1:0] min_q, min_d;
  logic [AW-1:0] midx_q, midx_d;
  logic [1:0] st_q, st_d;
  logic ovld_q;
  logic [63:0] odata_q;

  mem_ctl_t mc;
  logic [AW-1:0] wa, ra, rb;
  logic [DW-1:0] wd, qa, qb;

  bmhq_store #(.AW(AW), .DW(DW)) u_store (
    .clk_i(clk_i), .we_i(mc.wr_en), .wa_i(wa), .wd_i(wd),
    .ra_i(ra), .rb_i(rb), .qa_o(qa), .qb_o(qb)
  );

  logic [CW-1:0] cap_eff;
  logic [KEY_BITS-1:0] in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic [CW:0] lidx, ridx;
  logic [CW-1:0] last;

  assign in_key  = s_axis_tdata[KEY_BITS-1:0];
  assign in_pay  = s_axis_tdata[KEY_BITS +: PAYLOAD_BITS];
  assign cap_eff = ({25'd0, cap_q} > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
  assign lidx    = (CW+1)'({pos_q, 1'b1});
  assign ridx    = lidx + 1'b1;
  assign last    = cnt_q - 1'b1;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && (!ovld_q || m_axis_tready);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  // Sequencer: next state, store accesses and datapath updates.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; req_d = req_q; ent_d = ent_q;
    res_d = res_q; pos_d = pos_q; scan_d = scan_q; min_d = min_q;
    midx_d = midx_q; st_d = st_q;
    mc = '0; wa = pos_q; wd = ent_q; ra = '0; rb = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          req_d = s_axis_tuser; st_d = ST_DONE; res_d = '0;
          priority if (s_axis_tuser == REQ_INSERT) begin
            if (cnt_q >= cap_eff) begin
              st_d = ST_FULL; state_d = S_DONE;
            end else begin
              ent_d = {in_pay, in_key}; pos_d = AW'(cnt_q);
              cnt_d = cnt_q + 1'b1; state_d = S_UP_RD;
            end
          end else if (s_axis_tuser == REQ_EXT_MAX || s_axis_tuser == REQ_EXT_MIN) begin
            if (cnt_q == '0) begin
              st_d = ST_EMPTY; state_d = S_DONE;
            end else begin
              ra = '0; midx_d = '0; scan_d = CW'(1);
              state_d = S_RD_ROOT;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD_ROOT: begin
        min_d = qa;
        if (req_q == REQ_EXT_MIN && scan_q < cnt_q) begin
          ra = AW'(scan_q); scan_d = scan_q + 1'b1; state_d = S_SCAN;
        end else begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN: begin
        // qa holds slot scan_q-1.
        if (qa[KEY_BITS-1:0] < min_q[KEY_BITS-1:0]) begin
          min_d = qa; midx_d = AW'(scan_q - 1'b1);
        end
        if (scan_q < cnt_q) begin
          ra = AW'(scan_q); scan_d = scan_q + 1'b1;
        end else begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        res_d = min_q; pos_d = midx_q; ra = AW'(last); state_d = S_RD_LAST;
      end
      S_RD_LAST: begin
        ent_d = qa; cnt_d = last;
        if (32'(pos_q) == 32'(last)) state_d = S_DONE;
        else state_d = S_PLACE;
      end
      S_PLACE: begin
        // Decide sift direction from the parent of the vacated slot.
        mc.wr_en = 1'b1;
        ra = AW'((pos_q - 1'b1) >> 1);
        state_d = (pos_q != '0) ? S_UP_RD : S_DN_RD;
        if (pos_q == '0) begin
          ra = AW'(lidx); rb = AW'(ridx);
        end
        if (req_q == REQ_EXT_MIN && pos_q != '0) state_d = S_UP_CMP;
      end
      S_UP_RD: begin
        mc.wr_en = 1'b1;
        if (pos_q == '0) state_d = S_DONE;
        else begin
          ra = AW'((pos_q - 1'b1) >> 1); state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (qa[KEY_BITS-1:0] < ent_q[KEY_BITS-1:0]) begin
          // Parent moves down; entry goes up.
          mc.wr_en = 1'b1; wd = qa;
          pos_d = AW'((pos_q - 1'b1) >> 1);
          req_d = REQ_INSERT; state_d = S_UP_RD;
        end else if (req_q == REQ_EXT_MIN) begin
          ra = AW'(lidx); rb = AW'(ridx); state_d = S_DN_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN_RD: begin
        ra = AW'(lidx); rb = AW'(ridx); state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        state_d = S_DONE;
        if (lidx < (CW+1)'(cnt_q)) begin
          if (ridx < (CW+1)'(cnt_q) && qb[KEY_BITS-1:0] > qa[KEY_BITS-1:0]) begin
            if (qb[KEY_BITS-1:0] > ent_q[KEY_BITS-1:0]) begin
              mc.wr_en = 1'b1; wd = qb; pos_d = AW'(ridx); state_d = S_DN_RD;
            end
          end else if (qa[KEY_BITS-1:0] > ent_q[KEY_BITS-1:0]) begin
            mc.wr_en = 1'b1; wd = qa; pos_d = AW'(lidx); state_d = S_DN_RD;
          end
        end
        if (state_d == S_DONE) begin
          mc.wr_en = 1'b1; wd = ent_q;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; cap_q <= CAP_BITS'(64); ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (state_q == S_DONE) ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d; ent_q <= ent_d; res_q <= res_d; pos_q <= pos_d;
    scan_q <= scan_d; min_q <= min_d; midx_q <= midx_d; st_q <= st_d;
    if (state_q == S_DONE) begin
      odata_q <= {7'd0, 7'(cnt_q), st_q, 16'(res_q[DW-1:KEY_BITS]),
                  32'(res_q[KEY_BITS-1:0])};
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("count above depth");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) |=> cnt_q <= cap_eff || $stable(cnt_q))
    else $error("insert beyond capacity");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> m_axis_tvalid)
    else $error("result lost");
endmodule
`default_nettype wire
